// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the ring allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rfa_pkg.sv =====
// Shared types and constants of the ring resource allocator.
`timescale 1ns / 1ps
`default_nettype none

package rfa_pkg;

    // Ring dimensions and field widths.
    localparam int MAX_CLIENTS = 16;
    localparam int ID_W        = 4;
    localparam int RING_W      = 5;
    localparam int THR_W       = 4;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    // Reset values of the configuration registers.
    localparam logic [RING_W-1:0] RING_RESET = RING_W'(5);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(2);

    // Saturation value of a denial counter.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STARVE_THR = CFG_IDX_W'(1);

    // Request operations.
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_DENIED   = 2'd1,
        ST_RELEASED = 2'd2,
        ST_BAD_ID   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    // One result item.
    typedef struct packed {
        logic [ID_W-1:0] prio_client;
        logic            prio_active;
        logic            raised;
        status_t         status;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/ring_fork_allocator_antistarvation_core.sv =====
// Top level of the ring resource allocator with starvation priority.
//
//  Channel   Direction  Ports                               Contents
//  s_        in         s_tvalid s_tready s_tdata s_tuser   one acquire or release request
//  m_        out        m_tvalid m_tready m_tdata           one result per request
//  cfg_      in         cfg_valid cfg_ready cfg_index ...   ring size, starvation threshold
//
//  Each request is accepted in the idle state, which reads the client's denial counter from the
//  counter memory, then decided in the exec state, which writes the counter back and loads the result.
//  The read-modify-write on the counter memory allows only one request in work at once.
//  Reset is synchronous and active low; it frees every resource and clears every counter at once
//  through per-entry valid bits, so no clearing pass follows it.
//  A result that is not taken holds the block in its decide cycle; input is stalled meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module ring_fork_allocator_antistarvation_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Request channel.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rfa_pkg::S_TDATA_W-1:0]    s_tdata,   // [3:0] client_id, [7:4] zero
    input  wire logic [0:0]                       s_tuser,   // [0] op
    // Result channel.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [rfa_pkg::M_TDATA_W-1:0]    m_tdata,   // [1:0] status, [2] starvation_raised,
                                                             // [3] priority_active,
                                                             // [7:4] priority_client
    // Configuration write channel.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import rfa_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CLIENTS);

    fsm_t                   state_reg, state_next;
    logic [RING_W-1:0]      ring_reg, ring_next;
    logic [THR_W-1:0]       thr_reg, thr_next;
    logic [MAX_CLIENTS-1:0] busy_reg, busy_next;
    logic [MAX_CLIENTS-1:0] cnt_vld_reg, cnt_vld_next;
    logic                   prio_vld_reg, prio_vld_next;
    logic [ID_W-1:0]        prio_idx_reg, prio_idx_next;
    logic                   m_valid_reg, m_valid_next;
    result_t                m_data_reg, m_data_next;
    logic                   op_reg, op_next;
    logic [ID_W-1:0]        id_reg, id_next;

    logic                   s_fire;
    logic                   cfg_fire;
    logic                   exec_fire;
    logic [ID_W-1:0]        s_id;

    logic                   ram_we;
    logic [CNT_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [CNT_W-1:0]       ram_rdata;

    logic [RING_W-1:0]      n_eff;
    logic [RING_W-1:0]      n_minus1;
    logic [RING_W-1:0]      id_plus1;
    logic                   bad_id;
    logic [ID_W-1:0]        right_id;
    logic [ID_W-1:0]        left_id;
    logic                   blocked;
    logic [CNT_W-1:0]       cnt_cur;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   raise;

    // Handshakes.
    assign s_id      = s_tdata[ID_W-1:0];
    assign s_tready  = (state_reg == FSM_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign exec_fire = (state_reg == FSM_EXEC) && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.prio_client, m_data_reg.prio_active,
                       m_data_reg.raised, m_data_reg.status};

    // Denial counter memory; the read address follows the incoming request while idle.
    assign ram_raddr = (state_reg == FSM_IDLE) ? s_id : id_reg;

    rfa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CLIENTS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (id_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Ring geometry: clamp the ring size and find both neighbors.
    always_comb begin
        if (ring_reg == '0) begin
            n_eff = RING_W'(1);
        end else if (ring_reg > RING_W'(MAX_CLIENTS)) begin
            n_eff = RING_W'(MAX_CLIENTS);
        end else begin
            n_eff = ring_reg;
        end
        n_minus1 = n_eff - RING_W'(1);
        id_plus1 = {1'b0, id_reg} + RING_W'(1);
        bad_id   = ({1'b0, id_reg} >= n_eff);
        right_id = (id_plus1 == n_eff) ? '0 : id_plus1[ID_W-1:0];
        left_id  = (id_reg == '0) ? n_minus1[ID_W-1:0] : id_reg - ID_W'(1);
    end

    // Grant test and saturating denial count; entries not written since reset read as zero.
    always_comb begin
        blocked = busy_reg[id_reg] || busy_reg[right_id]
               || (prio_vld_reg && (left_id != id_reg) && (left_id == prio_idx_reg))
               || (prio_vld_reg && (right_id != id_reg) && (right_id == prio_idx_reg));
        cnt_cur = cnt_vld_reg[id_reg] ? ram_rdata : '0;
        cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
        raise   = (cnt_inc >= thr_reg);
    end

    // Sequencer: next state, state updates and the result.
    always_comb begin
        state_next    = state_reg;
        ring_next     = ring_reg;
        thr_next      = thr_reg;
        busy_next     = busy_reg;
        cnt_vld_next  = cnt_vld_reg;
        prio_vld_next = prio_vld_reg;
        prio_idx_next = prio_idx_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        ram_we        = 1'b0;
        ram_wdata     = cnt_inc;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_fire) begin
            case (cfg_index)
                CFG_RING_SIZE:  ring_next = cfg_data[RING_W-1:0];
                CFG_STARVE_THR: thr_next  = cfg_data[THR_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    op_next    = s_tuser[0];
                    id_next    = s_id;
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (exec_fire) begin
                    m_data_next.raised = 1'b0;
                    if (bad_id) begin
                        m_data_next.status = ST_BAD_ID;
                    end else if (op_reg == OP_RELEASE) begin
                        m_data_next.status = ST_RELEASED;
                        busy_next[id_reg]   = 1'b0;
                        busy_next[right_id] = 1'b0;
                    end else if (blocked) begin
                        m_data_next.status = ST_DENIED;
                        // Denials are counted only while nobody holds priority.
                        if (!prio_vld_reg) begin
                            ram_we               = 1'b1;
                            cnt_vld_next[id_reg] = 1'b1;
                            if (raise) begin
                                prio_vld_next      = 1'b1;
                                prio_idx_next      = id_reg;
                                m_data_next.raised = 1'b1;
                            end
                        end
                    end else begin
                        m_data_next.status   = ST_GRANTED;
                        cnt_vld_next[id_reg] = 1'b0;
                        busy_next[id_reg]    = 1'b1;
                        busy_next[right_id]  = 1'b1;
                        if (prio_vld_reg && (prio_idx_reg == id_reg)) begin
                            prio_vld_next = 1'b0;
                            prio_idx_next = '0;
                        end
                    end
                    m_data_next.prio_active = prio_vld_next;
                    m_data_next.prio_client = prio_idx_next;
                    m_valid_next            = 1'b1;
                    state_next              = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            ring_reg     <= RING_RESET;
            thr_reg      <= THR_RESET;
            busy_reg     <= '0;
            cnt_vld_reg  <= '0;
            prio_vld_reg <= 1'b0;
            prio_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ring_reg     <= ring_next;
            thr_reg      <= thr_next;
            busy_reg     <= busy_next;
            cnt_vld_reg  <= cnt_vld_next;
            prio_vld_reg <= prio_vld_next;
            prio_idx_reg <= prio_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
    end

endmodule

`default_nettype wire

// ===== sv/rfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/rfa_check.sv =====
// Port-level checker for the ring allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rfa_check (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [rfa_pkg::S_TDATA_W-1:0]    s_tdata,
    input wire logic [0:0]                       s_tuser,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [rfa_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready,
    input wire logic [rfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input wire logic [rfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import rfa_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser, cfg_valid, cfg_ready, cfg_index, cfg_data};

    // Reset empties the result register.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // A result that is not taken stays and keeps its value.
    `ASSERT_NEXT(a_hold, aclk, aresetn, aresetn && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // One request is worked on at a time.
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, aresetn && s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // Raising priority only happens on a denial and leaves the priority active.
    `ASSERT_IMPLY(a_raise_denied, aclk, aresetn, m_tvalid && m_tdata[2], (m_tdata[1:0] == ST_DENIED) && m_tdata[3], "priority raised without denial")

    // With no priority active, the reported client is zero.
    `ASSERT_IMPLY(a_idle_client, aclk, aresetn, m_tvalid && !m_tdata[3], m_tdata[7:4] == '0, "priority client set while inactive")

endmodule

bind ring_fork_allocator_antistarvation_core rfa_check u_rfa_check (.*);

`default_nettype wire

// ===== test/ring_fork_allocator_antistarvation_core_tb.sv =====
// Self-checking testbench for the ring resource allocator with starvation priority.
`timescale 1ns / 1ps

module ring_fork_allocator_antistarvation_core_tb;

    import rfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 250;

    // One acquire or release request as the driver sends it.
    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] client;
    } ring_req_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Requests waiting to be sent and outcomes waiting to come back.
    ring_req_t request_q[$];
    result_t   outcome_q[$];
    ring_req_t drv_req;
    logic      steady = 1'b0;
    int        errors = 0;
    int        stall_cycles = 0;

    // Mirror of the arbiter state and its configuration.
    logic [RING_W-1:0]      ring_cfg = RING_RESET;
    logic [THR_W-1:0]       thr_cfg = THR_RESET;
    logic [MAX_CLIENTS-1:0] fork_busy = '0;
    logic [CNT_W-1:0]       denials [MAX_CLIENTS];
    logic                   prio_on = 1'b0;
    logic [ID_W-1:0]        prio_id = '0;

    initial begin
        foreach (denials[k]) denials[k] = '0;
    end

    ring_fork_allocator_antistarvation_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [3:0] client_id, [7:4] zero
        .s_tuser   (s_tuser),   // [0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [1:0] status, [2] starvation_raised, [3] priority_active,
                                // [7:4] priority_client
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Number of clients actually on the ring for the current setting.
    function automatic int ring_clients();
        if (ring_cfg == 0) return 1;
        if (ring_cfg > MAX_CLIENTS) return MAX_CLIENTS;
        return int'(ring_cfg);
    endfunction

    // A neighbor blocks the client only when it holds priority and is not the client itself.
    function automatic logic blocks_client(int nb, int self);
        return prio_on && nb != self && nb == int'(prio_id);
    endfunction

    // Applies one request to the mirrored state and returns the result it should produce.
    function automatic result_t arbitrate(logic op, logic [ID_W-1:0] client);
        int      n;
        int      self;
        int      right;
        int      left;
        result_t r;
        n = ring_clients();
        self = int'(client);
        r.raised = 1'b0;
        if (self >= n) begin
            r.status = ST_BAD_ID;
        end else begin
            right = (self + 1 == n) ? 0 : self + 1;
            left = (self == 0) ? n - 1 : self - 1;
            if (op == OP_RELEASE) begin
                fork_busy[self] = 1'b0;
                fork_busy[right] = 1'b0;
                r.status = ST_RELEASED;
            end else if (fork_busy[self] || fork_busy[right] ||
                         blocks_client(left, self) || blocks_client(right, self)) begin
                r.status = ST_DENIED;
                // Denials only count while nobody is prioritized.
                if (!prio_on) begin
                    if (denials[self] != CNT_MAX) denials[self] = denials[self] + 1'b1;
                    if (denials[self] >= thr_cfg) begin
                        prio_on = 1'b1;
                        prio_id = client;
                        r.raised = 1'b1;
                    end
                end
            end else begin
                r.status = ST_GRANTED;
                denials[self] = '0;
                if (prio_on && prio_id == client) begin
                    prio_on = 1'b0;
                    prio_id = '0;
                end
                fork_busy[self] = 1'b1;
                fork_busy[right] = 1'b1;
            end
        end
        r.prio_active = prio_on;
        r.prio_client = prio_id;
        return r;
    endfunction

    // Request driver: sends queued requests and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(arbitrate(s_tuser[0], s_tdata[ID_W-1:0]));
            end
            if (!s_tvalid || s_tready) begin
                if (request_q.size() > 0 && (steady || $urandom_range(99) >= 18)) begin
                    drv_req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= S_TDATA_W'(drv_req.client);
                    s_tuser <= drv_req.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void report_field(string field, int expv, int gotv);
        $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, field, expv, gotv);
    endfunction

    // Result monitor: compares every accepted result with the oldest predicted outcome.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors <= errors + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        if (got.status !== want.status)
                            report_field("status", want.status, got.status);
                        if (got.raised !== want.raised)
                            report_field("starvation_raised", want.raised, got.raised);
                        if (got.prio_active !== want.prio_active)
                            report_field("priority_active", want.prio_active, got.prio_active);
                        if (got.prio_client !== want.prio_client)
                            report_field("priority_client", want.prio_client, got.prio_client);
                        errors <= errors + 1;
                    end
                end
            end
            m_tready <= steady || $urandom_range(99) >= 18;
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic add_request(logic op, int client);
        request_q.push_back('{op: op, client: ID_W'(client)});
    endtask

    // Writes one configuration register and mirrors it once the write is taken.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_RING_SIZE) ring_cfg = RING_W'(value);
        else if (idx == CFG_STARVE_THR) thr_cfg = THR_W'(value);
    endtask

    // Waits until every request is sent and answered, then lets the block settle.
    task automatic drain();
        do @(posedge aclk);
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly in-range traffic with bursts from one client to build up denials.
    task automatic load_random(int count);
        int n;
        int client;
        int burst;
        n = ring_clients();
        while (count > 0) begin
            if ($urandom_range(99) < 12) begin
                client = $urandom_range(n - 1);
                burst = $urandom_range(6, 3);
                repeat (burst) add_request(OP_ACQUIRE, client);
                count -= burst;
            end else begin
                client = ($urandom_range(99) < 88) ? $urandom_range(n - 1) : $urandom_range(15);
                add_request(($urandom_range(99) < 35) ? OP_RELEASE : OP_ACQUIRE, client);
                count--;
            end
        end
    endtask

    // Main sequence: reset, directed requests, then random phases over several settings.
    initial begin
        int ring_set [7];
        int thr_set [7];
        ring_set = '{1, 16, 0, 31, 2, 7, 4};
        thr_set = '{1, 15, 0, 19, 1, 4, 2};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests on the reset setting of five clients and a threshold of two.
        add_request(OP_ACQUIRE, 0);
        add_request(OP_ACQUIRE, 1);
        add_request(OP_ACQUIRE, 1);
        add_request(OP_ACQUIRE, 2);
        add_request(OP_ACQUIRE, 4);
        add_request(OP_RELEASE, 0);
        add_request(OP_ACQUIRE, 1);
        add_request(OP_ACQUIRE, 15);
        add_request(OP_RELEASE, 15);
        add_request(OP_ACQUIRE, 4);
        add_request(OP_RELEASE, 3);
        add_request(OP_ACQUIRE, 3);
        add_request(OP_ACQUIRE, 5);
        add_request(OP_RELEASE, 10);
        add_request(OP_ACQUIRE, 2);
        add_request(OP_ACQUIRE, 2);
        add_request(OP_RELEASE, 1);
        add_request(OP_RELEASE, 3);
        add_request(OP_RELEASE, 4);
        drain();

        // Writes to the unused register indexes must leave the setting alone.
        write_cfg(CFG_IDX_W'(2), 31);
        write_cfg(CFG_IDX_W'(3), 0);

        foreach (ring_set[p]) begin
            write_cfg(CFG_RING_SIZE, ring_set[p]);
            write_cfg(CFG_STARVE_THR, thr_set[p]);
            // The phase with a ring size of 16 runs with neither side idling.
            @(posedge aclk);
            steady <= (p == 1);
            load_random(PHASE_ITEMS);
            drain();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
